[sv/qsmp_pkg.sv]
// shared types and constants of the qr symbol module placer
package qsmp_pkg;

   localparam logic [4:0]  LAST_ROW   = 5'd28;
   localparam logic [3:0]  LAST_PAIR  = 4'd13;
   localparam logic [3:0]  RIGHT_LAST = 4'd10;
   localparam logic [4:0]  ALIGN_CTR  = 5'd22;
   localparam logic [4:0]  FAR_CTR    = 5'd25;
   localparam logic [4:0]  NEAR_CTR   = 5'd3;
   localparam logic [10:0] FMT_GEN    = 11'h537;
   localparam logic [14:0] FMT_XOR    = 15'h5412;

   typedef struct packed {
      logic take_item;
      logic restart;
      logic advance;
      logic store_bit;
      logic load_place;
      logic load_read;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic cell_is_data;
   } status_type;

endpackage

[sv/qsmp_ctrl.sv]
// sequencer for place and read items of the qr symbol module placer
module qsmp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic                 req_first,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qsmp_pkg::cmd_type    cmd,
   input  qsmp_pkg::status_type st
);
   import qsmp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SEEK  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               cmd.restart   = !req_action && req_first;
               state_in      = req_action ? ST_READ : ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (st.walk_done || st.cell_is_data) begin
               if (slot_free) begin
                  cmd.load_place = 1'b1;
                  cmd.store_bit  = !st.walk_done;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) begin
               cmd.load_read = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_place || cmd.load_read || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_store_with_result: assert property (@(posedge clock) disable iff (reset)
      cmd.store_bit |-> cmd.load_place)
      else $error("cell written without a result");
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_place || cmd.load_read) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a waiting item");
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |=> (state_ff != ST_IDLE))
      else $error("item taken but sequencer idle");
   a_step_or_finish: assert property (@(posedge clock) disable iff (reset)
      !(cmd.advance && (cmd.load_place || cmd.load_read)))
      else $error("walker stepped while finishing an item");
`endif

endmodule

[sv/qsmp_datapath.sv]
// walker, module store, function cell decode and result register
module qsmp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  qsmp_pkg::cmd_type    cmd,
   output qsmp_pkg::status_type st,
   input  logic                 req_bit_value,
   input  logic [4:0]           req_row,
   input  logic [4:0]           req_col,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_ec_level_code,
   output logic                 rsp_dark,
   output logic                 rsp_is_function,
   output logic [4:0]           rsp_placed_row,
   output logic [4:0]           rsp_placed_col,
   output logic                 rsp_overflow
);
   import qsmp_pkg::*;

   function automatic logic [4:0] absdiff(input logic [4:0] a, input logic [4:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [4:0] max5(input logic [4:0] a, input logic [4:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [14:0] format_word(input logic [1:0] ec);
      logic [4:0]  dat;
      logic [14:0] rem;
      dat = {ec, 3'b000};
      rem = {dat, 10'b0};
      for (int b = 14; b >= 10; b--) begin
         if (rem[b]) begin
            rem = rem ^ ({4'b0, FMT_GEN} << (b - 10));
         end
      end
      return {dat, rem[9:0]} ^ FMT_XOR;
   endfunction

   // returns {function cell, colour}
   function automatic logic [1:0] fixed_cell(input logic [4:0] r, input logic [4:0] c,
                                             input logic [14:0] fw);
      logic [4:0] m0;
      logic [4:0] m1;
      logic [4:0] m2;
      logic [4:0] ma;
      logic [4:0] idx;
      logic [1:0] res;
      m0  = max5(absdiff(r, NEAR_CTR), absdiff(c, NEAR_CTR));
      m1  = max5(absdiff(r, NEAR_CTR), absdiff(c, FAR_CTR));
      m2  = max5(absdiff(r, FAR_CTR), absdiff(c, NEAR_CTR));
      ma  = max5(absdiff(r, ALIGN_CTR), absdiff(c, ALIGN_CTR));
      idx = '0;
      res = 2'b00;
      priority if (m0 <= 5'd4) begin
         res = {1'b1, (m0 <= 5'd1) || (m0 == 5'd3)};
      end else if (m1 <= 5'd4) begin
         res = {1'b1, (m1 <= 5'd1) || (m1 == 5'd3)};
      end else if (m2 <= 5'd4) begin
         res = {1'b1, (m2 <= 5'd1) || (m2 == 5'd3)};
      end else if (ma <= 5'd2) begin
         res = {1'b1, ma != 5'd1};
      end else if (r == 5'd8 && c <= 5'd5) begin
         idx = 5'd14 - c;
         res = {1'b1, fw[idx[3:0]]};
      end else if (r == 5'd8 && c == 5'd7) begin
         res = {1'b1, fw[8]};
      end else if (r == 5'd8 && c == 5'd8) begin
         res = {1'b1, fw[7]};
      end else if (r == 5'd8 && c >= 5'd21) begin
         idx = 5'd28 - c;
         res = {1'b1, fw[idx[3:0]]};
      end else if (c == 5'd8 && r <= 5'd5) begin
         res = {1'b1, fw[r[3:0]]};
      end else if (c == 5'd8 && r == 5'd7) begin
         res = {1'b1, fw[6]};
      end else if (c == 5'd8 && r == 5'd21) begin
         res = 2'b11;
      end else if (c == 5'd8 && r >= 5'd22) begin
         idx = r - 5'd14;
         res = {1'b1, fw[idx[3:0]]};
      end else if (r == 5'd6) begin
         res = {1'b1, ~c[0]};
      end else if (c == 5'd6) begin
         res = {1'b1, ~r[0]};
      end else begin
         res = 2'b00;
      end
      return res;
   endfunction

   logic [1:0]  ec_level_ff, ec_level_in;
   logic        bit_ff, bit_in;
   logic [4:0]  row_ff, row_in;
   logic [4:0]  col_ff, col_in;
   logic [3:0]  pair_ff, pair_in;
   logic [4:0]  step_ff, step_in;
   logic        half_ff, half_in;
   logic        done_ff, done_in;
   logic        mem_q_ff;
   logic        module_mem [0:1023];

   logic        dark_ff, dark_in;
   logic        func_ff, func_in;
   logic [4:0]  prow_ff, prow_in;
   logic [4:0]  pcol_ff, pcol_in;
   logic        ovf_ff, ovf_in;

   logic [14:0] fw;
   logic [4:0]  pair_x2;
   logic [4:0]  right_col;
   logic [4:0]  walk_row;
   logic [4:0]  walk_col;
   logic [1:0]  walk_fc;
   logic [1:0]  read_fc;
   logic [4:0]  col_off_hi;
   logic [4:0]  col_off_lo;
   logic [3:0]  rc_pair;
   logic [4:0]  rc_step;
   logic        rc_half;
   logic        written;
   logic        in_range;

   assign csr_ready = 1'b1;
   assign fw        = format_word(ec_level_ff);

   // current walker cell
   assign pair_x2   = {pair_ff, 1'b0};
   assign right_col = (pair_ff <= RIGHT_LAST) ? 5'd28 - pair_x2 : 5'd27 - pair_x2;
   assign walk_col  = right_col - {4'b0, half_ff};
   assign walk_row  = pair_ff[0] ? step_ff : LAST_ROW - step_ff;
   assign walk_fc   = fixed_cell(walk_row, walk_col, fw);

   assign st.walk_done    = done_ff;
   assign st.cell_is_data = !walk_fc[1];

   // zigzag position of the read cell, compared with the walker's fill point
   assign col_off_hi = 5'd28 - col_ff;
   assign col_off_lo = 5'd5 - col_ff;
   assign rc_pair    = (col_ff >= 5'd7) ? col_off_hi[4:1] : 4'd11 + {2'b0, col_off_lo[2:1]};
   assign rc_half    = (col_ff >= 5'd7) ? col_ff[0] : ~col_ff[0];
   assign rc_step    = rc_pair[0] ? row_ff : LAST_ROW - row_ff;
   assign written    = done_ff || ({rc_pair, rc_step, rc_half} < {pair_ff, step_ff, half_ff});
   assign in_range   = (row_ff <= LAST_ROW) && (col_ff <= LAST_ROW);
   assign read_fc    = fixed_cell(row_ff, col_ff, fw);

   always_comb begin
      ec_level_in = (csr_valid && csr_ready) ? csr_ec_level_code : ec_level_ff;
      bit_in      = cmd.take_item ? req_bit_value : bit_ff;
      row_in      = cmd.take_item ? req_row : row_ff;
      col_in      = cmd.take_item ? req_col : col_ff;
   end

   always_comb begin
      pair_in = pair_ff;
      step_in = step_ff;
      half_in = half_ff;
      done_in = done_ff;
      if (cmd.restart) begin
         pair_in = '0;
         step_in = '0;
         half_in = 1'b0;
         done_in = 1'b0;
      end else if (cmd.advance || cmd.store_bit) begin
         if (!half_ff) begin
            half_in = 1'b1;
         end else begin
            half_in = 1'b0;
            if (step_ff == LAST_ROW) begin
               step_in = '0;
               if (pair_ff == LAST_PAIR) begin
                  done_in = 1'b1;
               end else begin
                  pair_in = pair_ff + 4'd1;
               end
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
      end
   end

   always_comb begin
      dark_in = dark_ff;
      func_in = func_ff;
      prow_in = prow_ff;
      pcol_in = pcol_ff;
      ovf_in  = ovf_ff;
      if (cmd.load_place) begin
         func_in = 1'b0;
         if (done_ff) begin
            dark_in = 1'b0;
            prow_in = '0;
            pcol_in = '0;
            ovf_in  = 1'b1;
         end else begin
            dark_in = bit_ff ^ ~(walk_row[0] ^ walk_col[0]);
            prow_in = walk_row;
            pcol_in = walk_col;
            ovf_in  = 1'b0;
         end
      end else if (cmd.load_read) begin
         prow_in = '0;
         pcol_in = '0;
         ovf_in  = 1'b0;
         if (!in_range) begin
            dark_in = 1'b0;
            func_in = 1'b0;
         end else if (read_fc[1]) begin
            dark_in = read_fc[0];
            func_in = 1'b1;
         end else begin
            dark_in = (written & mem_q_ff) ^ ~(row_ff[0] ^ col_ff[0]);
            func_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ec_level_ff <= '0;
         pair_ff     <= '0;
         step_ff     <= '0;
         half_ff     <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         ec_level_ff <= ec_level_in;
         pair_ff     <= pair_in;
         step_ff     <= step_in;
         half_ff     <= half_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      dark_ff <= dark_in;
      func_ff <= func_in;
      prow_ff <= prow_in;
      pcol_ff <= pcol_in;
      ovf_ff  <= ovf_in;
   end

   // module store, addressed by {row, col}
   always_ff @(posedge clock) begin
      if (cmd.store_bit) begin
         module_mem[{walk_row, walk_col}] <= bit_ff;
      end
      mem_q_ff <= module_mem[{row_ff, col_ff}];
   end

   assign rsp_dark        = dark_ff;
   assign rsp_is_function = func_ff;
   assign rsp_placed_row  = prow_ff;
   assign rsp_placed_col  = pcol_ff;
   assign rsp_overflow    = ovf_ff;

`ifndef SYNTH
   a_walker_range: assert property (@(posedge clock) disable iff (reset)
      (pair_ff <= LAST_PAIR) && (step_ff <= LAST_ROW))
      else $error("walker out of range");
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !cmd.restart) |=> done_ff)
      else $error("exhausted walker resumed without restart");
   a_no_store_when_done: assert property (@(posedge clock) disable iff (reset)
      cmd.store_bit |-> (!done_ff && !walk_fc[1]))
      else $error("store into a function cell or after exhaustion");
`endif

endmodule

[sv/qr_symbol_module_placer.sv]
// top level of the qr version 3 symbol module placer
// Builds a 29x29 version-3 symbol with mask 000. A place item (action 0) stores one codeword
// bit in the next free data cell of the two-column zigzag and reports that cell; a first flag
// restarts the walk and empties the store without a clearing pass, since a cell counts as
// written only if the walker has already passed it. A place item first steps the walker over
// any function cells before the next free data cell, one cell per cycle, then stores the bit.
// A read item passes through a read state, which waits for the registered read of the module
// store, and a reply state. Once all data cells are used, place items return overflow. Results
// wait in an output register, so the next item is taken while a result is still stalled.
module qr_symbol_module_placer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic       req_first,
   input  logic       req_bit_value,
   input  logic [4:0] req_row,
   input  logic [4:0] req_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_dark,
   output logic       rsp_is_function,
   output logic [4:0] rsp_placed_row,
   output logic [4:0] rsp_placed_col,
   output logic       rsp_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_ec_level_code
);
   import qsmp_pkg::*;

   cmd_type    cmd;
   status_type st;

   qsmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_first  (req_first),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .st         (st)
   );

   qsmp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_bit_value     (req_bit_value),
      .req_row           (req_row),
      .req_col           (req_col),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_ec_level_code (csr_ec_level_code),
      .rsp_dark          (rsp_dark),
      .rsp_is_function   (rsp_is_function),
      .rsp_placed_row    (rsp_placed_row),
      .rsp_placed_col    (rsp_placed_col),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

[verif/testbench.sv]
// testbench for the qr version 3 symbol module placer, checked against a predictor
`timescale 1ns / 100ps

module testbench;
   import qsmp_pkg::*;

   localparam int SIDE        = 29;
   localparam int WALK_CAP    = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 250;
   localparam int TAIL_CYCLES = 100;
   localparam int DRAIN_LIMIT = 20000;

   typedef enum logic {
      ACT_PLACE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef struct packed {
      logic       dark;
      logic       is_function;
      logic [4:0] placed_row;
      logic [4:0] placed_col;
      logic       overflow;
   } module_result_type;

   logic       clock;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   action_type req_action        = ACT_PLACE;
   logic       req_first         = 1'b0;
   logic       req_bit_value     = 1'b0;
   logic [4:0] req_row           = '0;
   logic [4:0] req_col           = '0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic       rsp_dark;
   logic       rsp_is_function;
   logic [4:0] rsp_placed_row;
   logic [4:0] rsp_placed_col;
   logic       rsp_overflow;
   logic       csr_valid         = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_ec_level_code = '0;

   // predictor state
   logic [SIDE*SIDE-1:0] symbol_store = '0;
   logic [4:0]           walk_r       = LAST_ROW;
   logic [5:0]           walk_c       = 6'd29;
   logic                 walk_up      = 1'b0;
   logic                 walk_rh      = 1'b1;
   logic                 walk_end     = 1'b0;
   logic [1:0]           ec_level     = 2'd0;

   module_result_type pending_modules[$];
   int                error_count = 0;
   int                cycle_count = 0;
   logic              idle_on     = 1'b1;
   int                hold_ask    = 0;
   int                hold_seen   = 0;
   int                hold_left   = 0;
   int                stall_left  = 0;

   qr_symbol_module_placer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_first         (req_first),
      .req_bit_value     (req_bit_value),
      .req_row           (req_row),
      .req_col           (req_col),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dark          (rsp_dark),
      .rsp_is_function   (rsp_is_function),
      .rsp_placed_row    (rsp_placed_row),
      .rsp_placed_col    (rsp_placed_col),
      .rsp_overflow      (rsp_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_ec_level_code (csr_ec_level_code)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   function automatic logic [14:0] format_bits(input logic [1:0] code);
      logic [14:0] rem;
      logic [4:0]  info;
      int          b;
      info = {code, 3'b000};
      rem  = {info, 10'b0};
      for (b = 14; b >= 10; b--) begin
         if (rem[b]) rem = rem ^ ({4'b0, FMT_GEN} << (b - 10));
      end
      return {info, rem[9:0]} ^ FMT_XOR;
   endfunction

   // {is function cell, colour}
   function automatic logic [1:0] fixed_module(input int r, input int c);
      logic [14:0] fmt;
      int          k, cr, cc, dr, dc, m;
      fmt = format_bits(ec_level);
      for (k = 0; k < 3; k++) begin
         cr = (k == 2) ? int'(FAR_CTR) : int'(NEAR_CTR);
         cc = (k == 1) ? int'(FAR_CTR) : int'(NEAR_CTR);
         dr = (r > cr) ? r - cr : cr - r;
         dc = (c > cc) ? c - cc : cc - c;
         m  = (dr > dc) ? dr : dc;
         if (m <= 4) return {1'b1, logic'(m <= 1 || m == 3)};
      end
      dr = (r > int'(ALIGN_CTR)) ? r - int'(ALIGN_CTR) : int'(ALIGN_CTR) - r;
      dc = (c > int'(ALIGN_CTR)) ? c - int'(ALIGN_CTR) : int'(ALIGN_CTR) - c;
      m  = (dr > dc) ? dr : dc;
      if (m <= 2) return {1'b1, logic'(m != 1)};
      if (r == 8) begin
         if (c <= 5) return {1'b1, fmt[14 - c]};
         if (c == 7) return {1'b1, fmt[8]};
         if (c == 8) return {1'b1, fmt[7]};
         if (c >= SIDE - 8) return {1'b1, fmt[SIDE - 1 - c]};
      end
      if (c == 8) begin
         if (r <= 5) return {1'b1, fmt[r]};
         if (r == 7) return {1'b1, fmt[6]};
         if (r == SIDE - 8) return 2'b11;
         if (r >= SIDE - 7) return {1'b1, fmt[r - (SIDE - 15)]};
      end
      if (r == 6) return {1'b1, logic'((c % 2) == 0)};
      if (c == 6) return {1'b1, logic'((r % 2) == 0)};
      return 2'b00;
   endfunction

   function automatic logic mask_of(input int r, input int c);
      return ((r + c) % 2) == 0;
   endfunction

   // one zigzag move, 0 when the path is used up
   function automatic bit advance_walker();
      if (walk_r >= LAST_ROW && walk_c == 0) return 1'b0;
      if (walk_rh && ((walk_r == 0 && walk_up) || (walk_r == LAST_ROW && !walk_up))) begin
         walk_c  = (walk_c > 0) ? walk_c - 6'd1 : 6'd0;
         if (walk_c == 6) walk_c = 6'd5;
         walk_up = !walk_up;
         walk_rh = 1'b0;
         return 1'b1;
      end
      if (walk_rh) begin
         if (walk_up) begin
            if (walk_r > 0) walk_r = walk_r - 5'd1;
         end else if (walk_r < LAST_ROW) begin
            walk_r = walk_r + 5'd1;
         end
         walk_c = walk_c + 6'd1;
      end else if (walk_c > 0) begin
         walk_c = walk_c - 6'd1;
      end
      walk_rh = !walk_rh;
      return 1'b1;
   endfunction

   function automatic module_result_type predict_module(input action_type act, input logic first,
                                                        input logic bitv, input logic [4:0] r,
                                                        input logic [4:0] c);
      module_result_type res;
      logic [1:0]        fx;
      logic              found;
      int                n;
      res = '0;
      if (act == ACT_READ) begin
         if (r < SIDE && c < SIDE) begin
            fx = fixed_module(int'(r), int'(c));
            if (fx[1]) begin
               res.dark        = fx[0];
               res.is_function = 1'b1;
            end else begin
               res.dark = symbol_store[r * SIDE + c] ^ mask_of(int'(r), int'(c));
            end
         end
         return res;
      end
      if (first) begin
         symbol_store = '0;
         walk_r       = LAST_ROW;
         walk_c       = 6'd29;
         walk_up      = 1'b0;
         walk_rh      = 1'b1;
         walk_end     = 1'b0;
      end
      found = 1'b0;
      for (n = 0; n < WALK_CAP && !walk_end && !found; n++) begin
         if (!advance_walker()) begin
            walk_end = 1'b1;
         end else if (walk_c < SIDE) begin
            fx = fixed_module(int'(walk_r), int'(walk_c));
            if (!fx[1]) begin
               symbol_store[walk_r * SIDE + walk_c] = bitv;
               res.dark       = bitv ^ mask_of(int'(walk_r), int'(walk_c));
               res.placed_row = walk_r;
               res.placed_col = walk_c[4:0];
               found          = 1'b1;
            end
         end
      end
      if (!found) begin
         walk_end     = 1'b1;
         res.overflow = 1'b1;
      end
      return res;
   endfunction

   task automatic send_item(input action_type act, input logic first, input logic bitv,
                            input logic [4:0] r, input logic [4:0] c);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_first     <= first;
      req_bit_value <= bitv;
      req_row       <= r;
      req_col       <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_modules.push_back(predict_module(act, first, bitv, r, c));
   endtask

   task automatic write_ec_level(input logic [1:0] code);
      req_valid <= 1'b0;
      while (pending_modules.size() != 0) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_ec_level_code <= code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ec_level = code;
   endtask

   function automatic logic [4:0] pick_coord();
      return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(29, 31))
                                         : 5'($urandom_range(0, 28));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [4:0] rand_any();
      return 5'($urandom_range(0, 31));
   endfunction

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         send_item(ACT_READ, rand_bit(), rand_bit(), pick_coord(), pick_coord());
      end else begin
         send_item(ACT_PLACE, pick > 95, rand_bit(), rand_any(), rand_any());
      end
   endtask

   task automatic test_reset_reads();
      send_item(ACT_READ, 1'b1, 1'b1, 5'd0, 5'd0);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd7, 5'd7);
      send_item(ACT_READ, 1'b0, 1'b1, 5'd8, 5'd8);
      send_item(ACT_READ, 1'b1, 1'b0, 5'd21, 5'd8);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd22, 5'd22);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd20, 5'd20);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd6, 5'd10);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd11, 5'd6);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd28, 5'd28);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd9, 5'd10);
      send_item(ACT_READ, 1'b1, 1'b1, 5'd31, 5'd31);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd29, 5'd0);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd0, 5'd29);
   endtask

   task automatic test_format_levels();
      write_ec_level(2'd3);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd8, 5'd0);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd0, 5'd8);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd28, 5'd8);
      write_ec_level(2'd0);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd8, 5'd28);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd8, 5'd2);
   endtask

   task automatic test_first_restart();
      send_item(ACT_PLACE, 1'b1, 1'b1, 5'd31, 5'd0);
      send_item(ACT_PLACE, 1'b0, 1'b0, 5'd0, 5'd31);
      send_item(ACT_PLACE, 1'b1, 1'b1, 5'd0, 5'd0);
      send_item(ACT_PLACE, 1'b0, 1'b1, 5'd31, 5'd31);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd28, 5'd28);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd28, 5'd27);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd27, 5'd28);
   endtask

   // fills every data cell and runs past the end of the path
   task automatic test_full_symbol();
      int n;
      write_ec_level(2'd2);
      send_item(ACT_PLACE, 1'b1, rand_bit(), 5'd31, 5'd31);
      for (n = 1; n < 575; n++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_item(ACT_READ, rand_bit(), rand_bit(), pick_coord(), pick_coord());
         end
         send_item(ACT_PLACE, 1'b0, rand_bit(), rand_any(), rand_any());
      end
      for (n = 0; n < 20; n++) begin
         send_item(ACT_READ, 1'b0, 1'b0, 5'($urandom_range(0, 28)), 5'($urandom_range(0, 28)));
      end
      send_item(ACT_PLACE, 1'b1, 1'b1, 5'd0, 5'd0);
      send_item(ACT_READ, 1'b0, 1'b0, 5'd28, 5'd28);
   endtask

   task automatic test_random_symbols();
      int s, n;
      for (s = 0; s < 4; s++) begin
         write_ec_level(2'($urandom_range(0, 3)));
         send_item(ACT_PLACE, 1'b1, rand_bit(), rand_any(), rand_any());
         repeat ($urandom_range(8, 24)) send_random_item();
      end
      // unbroken run of places with scattered reads
      send_item(ACT_PLACE, 1'b1, rand_bit(), 5'd0, 5'd0);
      for (n = 0; n < 40; n++) begin
         if ($urandom_range(0, 5) == 0) begin
            send_item(ACT_READ, 1'b0, 1'b1, pick_coord(), pick_coord());
         end
         send_item(ACT_PLACE, 1'b0, rand_bit(), rand_any(), rand_any());
      end
   endtask

   task automatic test_backpressure();
      hold_ask <= hold_ask + 1;
      repeat (30) send_random_item();
   endtask

   task automatic test_quiet_tail();
      write_ec_level(2'd1);
      idle_on <= 1'b0;
      send_item(ACT_PLACE, 1'b1, 1'b0, 5'd0, 5'd0);
      repeat (60) send_random_item();
   endtask

   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = int'($urandom_range(1, 17)) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      module_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_dark, rsp_is_function, rsp_placed_row, rsp_placed_col, rsp_overflow};
         if (pending_modules.size() == 0) begin
            note_error("result with no item pending");
         end else begin
            want = pending_modules.pop_front();
            if (got.dark !== want.dark || got.is_function !== want.is_function ||
                got.placed_row !== want.placed_row || got.placed_col !== want.placed_col ||
                got.overflow !== want.overflow) begin
               note_error($sformatf(
                  {"mismatch: expected dark %0d fn %0d row %0d col %0d ovf %0d,",
                   " got %0d %0d %0d %0d %0d"},
                  want.dark, want.is_function, want.placed_row, want.placed_col, want.overflow,
                  got.dark, got.is_function, got.placed_row, got.placed_col, got.overflow));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int wait_cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_reads();
      test_format_levels();
      test_first_restart();
      test_full_symbol();
      test_random_symbols();
      test_backpressure();
      test_quiet_tail();
      req_valid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && pending_modules.size() != 0;
           wait_cycles++) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_modules.size() != 0) begin
         note_error($sformatf("%0d results never arrived", pending_modules.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
sv/qsmp_pkg.sv
sv/qsmp_ctrl.sv
sv/qsmp_datapath.sv
sv/qr_symbol_module_placer.sv
verif/testbench.sv
